[hw/rtl/swmmm_pkg.sv]
// Shared constants, types and state encoding for the sliding window min/max/mean block.
package swmmm_pkg;

  localparam int WINDOW    = 50;
  localparam int SAMPLE_W  = 24;
  localparam int ADDR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW + 1);
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 96;

  // |sum| / WINDOW as (|sum| * DIV_RECIP) >> DIV_SHIFT, exact for |sum| < 2^(SUM_W-1)
  localparam int DIV_SHIFT = (SUM_W - 1) + $clog2(WINDOW);
  localparam logic [SUM_W-1:0] DIV_RECIP =
    SUM_W'(((64'd1 << DIV_SHIFT) + WINDOW - 1) / WINDOW);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_SCAN,
    ST_FINISH,
    ST_OUT
  } swmmm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request, negate sample
    logic update;  // write ring, update sum and pointers
    logic start;   // reset scan, capture |sum| for the mean
    logic scan;    // scan step, reciprocal multiply
    logic finish;  // fix sign of the mean
  } swmmm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
  } swmmm_stat_t;

endpackage

[hw/rtl/swmmm_ram.sv]
// Generic single write port, single read port RAM with registered read.
module swmmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/swmmm_ctrl.sv]
// Controller state machine: sequences update, scan/divide and result handoff.
module swmmm_ctrl
  import swmmm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output swmmm_cmd_t  cmd,
  input  swmmm_stat_t stat
);

  swmmm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_START;
      end
      ST_START: begin
        cmd.start = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/swmmm_dp.sv]
// Datapath: sample ring, running sum, min/max scan and reciprocal divide by the window size.
module swmmm_dp
  import swmmm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [SAMPLE_W-1:0]        sample,
  input  swmmm_cmd_t                 cmd,
  output swmmm_stat_t                stat,
  output logic signed [SAMPLE_W-1:0] neg_o,
  output logic signed [SAMPLE_W-1:0] min_o,
  output logic signed [SAMPLE_W-1:0] max_o,
  output logic signed [SAMPLE_W-1:0] mean_o
);

  localparam logic [CNT_W-1:0]   WIN_CNT = CNT_W'(WINDOW);
  localparam logic [ADDR_W-1:0]  LAST_SLOT = ADDR_W'(WINDOW - 1);
  localparam int                 PROD_W = DIV_SHIFT + SAMPLE_W;

  // control state
  logic [ADDR_W-1:0]       slot_r;
  logic [CNT_W-1:0]        fill_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]        idx_r;
  logic                    rdv_r;
  logic                    first_r;

  // payload
  logic signed [SAMPLE_W-1:0] neg_r;
  logic signed [SAMPLE_W-1:0] lo_r;
  logic signed [SAMPLE_W-1:0] hi_r;
  logic [SUM_W-1:0]           dq_r;
  logic [SAMPLE_W-1:0]        quot_r;
  logic                       dneg_r;
  logic signed [SAMPLE_W-1:0] mean_r;

  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SAMPLE_W-1:0] rd_s;
  logic [ADDR_W-1:0]          raddr;
  logic                       full;
  logic                       rd_issue;
  logic signed [SUM_W-1:0]    old_ext;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic signed [SAMPLE_W-1:0] neg_nxt;
  logic [PROD_W-1:0]          prod;

  assign full     = (fill_r == WIN_CNT);
  assign rd_issue = cmd.scan && (idx_r < fill_r);
  assign raddr    = rd_issue ? idx_r[ADDR_W-1:0] : slot_r;
  assign rd_s     = $signed(rdata);

  swmmm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (slot_r),
    .wdata (neg_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign neg_nxt = ($signed(sample) == SAMPLE_MIN) ? SAMPLE_MAX : -$signed(sample);

  // read of the slot being replaced was issued while idle
  assign old_ext = full ? SUM_W'(rd_s) : '0;
  assign sum_nxt = sum_r - old_ext + SUM_W'(neg_r);

  // |sum| is below 2^(SUM_W-1); upper product bits past the quotient are zero
  assign prod = PROD_W'(dq_r[SUM_W-2:0]) * PROD_W'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      fill_r  <= '0;
      sum_r   <= '0;
      idx_r   <= '0;
      rdv_r   <= 1'b0;
      first_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        sum_r  <= sum_nxt;
        slot_r <= (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
        if (!full) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cmd.start) begin
        idx_r   <= '0;
        rdv_r   <= 1'b0;
        first_r <= 1'b1;
      end else if (cmd.scan) begin
        rdv_r <= rd_issue;
        if (rd_issue) begin
          idx_r <= idx_r + 1'b1;
        end
        if (rdv_r) begin
          first_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= neg_nxt;
    end
    if (cmd.start) begin
      dneg_r <= sum_r[SUM_W-1];
      dq_r   <= sum_r[SUM_W-1] ? $unsigned(-sum_r) : $unsigned(sum_r);
    end else if (cmd.scan) begin
      if (rdv_r) begin
        if (first_r || rd_s < lo_r) begin
          lo_r <= rd_s;
        end
        if (first_r || rd_s > hi_r) begin
          hi_r <= rd_s;
        end
      end
      // dq_r holds steady through the scan
      quot_r <= prod[PROD_W-1:DIV_SHIFT];
    end
    if (cmd.finish) begin
      mean_r <= dneg_r ? -$signed(quot_r) : $signed(quot_r);
    end
  end

  assign stat.scan_done = (idx_r == fill_r) && !rdv_r;

  assign neg_o  = neg_r;
  assign min_o  = lo_r;
  assign max_o  = hi_r;
  assign mean_o = mean_r;

endmodule

[hw/rtl/sliding_window_min_max_mean.sv]
// Top level: negated rate sample with window minimum, maximum and mean over the last 50 samples.
// After a request is accepted: ring/sum update, scan start, ring scan, mean sign fix, then out_tvalid.
// The ring scan (one RAM read per cycle over the 1..50 samples held) sets the request rate;
//   the mean multiply runs beside it.
// One request in flight: in_tready drops on accept and returns once the result is taken.
// Reset (rst_n low, synchronous): window emptied, sum zero, no result pending; ring left as is.
module sliding_window_min_max_mean
  import swmmm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: [23:0] rate_sample
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: [23:0] negated_rate, [47:24] window_min, [71:48] window_max,
  //            [95:72] window_mean
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  swmmm_cmd_t  cmd;
  swmmm_stat_t stat;

  logic signed [SAMPLE_W-1:0] neg_v;
  logic signed [SAMPLE_W-1:0] min_v;
  logic signed [SAMPLE_W-1:0] max_v;
  logic signed [SAMPLE_W-1:0] mean_v;

  // sequencing: idle -> update ring/sum -> start -> scan+divide -> finish -> hold result
  swmmm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // ring RAM, running sum, min/max compare, divider; results stay registered until taken
  swmmm_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .sample (in_tdata[SAMPLE_W-1:0]),
    .cmd    (cmd),
    .stat   (stat),
    .neg_o  (neg_v),
    .min_o  (min_v),
    .max_o  (max_v),
    .mean_o (mean_v)
  );

  assign out_tdata = {mean_v, max_v, min_v, neg_v};

endmodule

[hw/rtl/swmmm_chk.sv]
// Port-level checker for the sliding window block, bound to the top level.
module swmmm_chk
  import swmmm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic signed [SAMPLE_W-1:0] neg_f, min_f, max_f;

  assign neg_f = $signed(out_tdata[SAMPLE_W-1:0]);
  assign min_f = $signed(out_tdata[2*SAMPLE_W-1:SAMPLE_W]);
  assign max_f = $signed(out_tdata[3*SAMPLE_W-1:2*SAMPLE_W]);

  // no result pending right after reset
  a_reset_idle: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("result pending after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // one request in flight: no new request while a result waits
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while result pending");

  // accepted request never shows a result on the next edge
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("result appeared too early");

  // newest sample is in the window, so it lies between min and max
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (min_f <= neg_f) && (neg_f <= max_f))
    else $error("window min/max inconsistent with newest sample");

endmodule

bind sliding_window_min_max_mean swmmm_chk u_swmmm_chk (.*);
